>>> rtl/lkv_pkg.sv
`timescale 1ns / 1ps
package lkv_pkg;
	localparam int CAPACITY_DEF   = 16;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 31;

	typedef struct packed {
		logic        action;
		logic [31:0] lookup_key;
		logic [30:0] store_value;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic [30:0] read_value;
		logic        evicted;
		logic [31:0] evicted_key;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_SET = 1'b1;
endpackage

>>> rtl/lru_key_value_cache.sv
`timescale 1ns / 1ps
// Fully associative key/value cache with least-recently-used replacement.
// A request beat is taken when start is high and busy is low; its fields
// arrive as one packed struct on req. Exactly one response beat follows,
// shown on rsp for a single cycle with done high; the receiver cannot stall
// it, so it must be captured in that cycle.
// Keys and values sit in synchronous memories of one read port, so the
// request walks every slot, one slot read per cycle. Busy is high until
// done rises, so the next request can be taken at the edge that ends the
// done cycle; no request is taken while one is still in progress.
// In the walk the block finds the matching key and the oldest valid slot;
// at the end a set writes the value (and, on a miss, the key) back, and
// recency ranks age; the ranks live in flip-flops beside the valid bits.
// cfg_we writes active_entries (reset 16); zero acts as one, values above
// the capacity act as the capacity. Write it only while busy is low.
// Reset empties the cache at once: valid bits, ranks and the fill count
// clear, and the key and value memories need no clearing pass.
module lru_key_value_cache #(
	parameter int CAPACITY   = lkv_pkg::CAPACITY_DEF,
	parameter int KEY_BITS   = lkv_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = lkv_pkg::VALUE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lkv_pkg::req_t req,
	output logic          done,
	output lkv_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic [4:0]    cfg_wdata
);
	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	lkv_pkg::state_t state_q, state_d;
	logic [KEY_BITS-1:0]   key_mem [CAPACITY];
	logic [VALUE_BITS-1:0] val_mem [CAPACITY];
	logic [CAPACITY-1:0]   valid_q;
	logic [IW-1:0]         rank_q [CAPACITY];
	logic [CW-1:0]         used_q;
	logic [4:0]            active_q;

	logic                  act_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [CW-1:0]         idx_q;      // address issued this cycle
	logic [IW-1:0]         rd_idx_q;   // address whose data is now out
	logic                  rd_vld_q;
	logic [KEY_BITS-1:0]   rkey_q;
	logic [VALUE_BITS-1:0] rval_q;
	logic                  found_q, any_q;
	logic [IW-1:0]         fidx_q, vidx_q;
	logic [IW-1:0]         vrank_q;
	logic [KEY_BITS-1:0]   vkey_q;
	logic [VALUE_BITS-1:0] fval_q;

	logic                  done_q;
	lkv_pkg::rsp_t         rsp_q;

	logic accept, scan_last;
	logic [CW-1:0] cap_eff;
	logic [7:0] act_ext;

	assign accept = start && (state_q == lkv_pkg::ST_IDLE);
	assign scan_last = (idx_q == CW'(CAPACITY));
	assign busy = (state_q != lkv_pkg::ST_IDLE);
	assign done = done_q;
	assign rsp = rsp_q;

	// Effective capacity from the register.
	always_comb begin
		act_ext = {3'b000, active_q};
		if (active_q == 5'd0) begin
			cap_eff = CW'(1);
		end else if (act_ext > 8'(CAPACITY)) begin
			cap_eff = CW'(CAPACITY);
		end else begin
			cap_eff = CW'(active_q);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lkv_pkg::ST_IDLE:   if (start) state_d = lkv_pkg::ST_SCAN;
			lkv_pkg::ST_SCAN:   if (scan_last) state_d = lkv_pkg::ST_FINISH;
			lkv_pkg::ST_FINISH: state_d = lkv_pkg::ST_IDLE;
			default:            state_d = lkv_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkv_pkg::ST_IDLE;
			active_q <= 5'd16;
		end else begin
			state_q <= state_d;
			if (cfg_we) active_q <= cfg_wdata;
		end
	end

	// Decisions taken at the end of the walk.
	logic       do_wr, wr_fill, wr_evict;
	logic [IW-1:0] wr_idx, mru_idx, old_rank;
	logic       do_age, age_all;

	always_comb begin
		wr_fill  = 1'b0;
		wr_evict = 1'b0;
		do_age   = 1'b0;
		age_all  = 1'b0;
		mru_idx  = fidx_q;
		old_rank = rank_q[fidx_q];
		if (found_q) begin
			do_age = 1'b1;
		end else if (act_q == lkv_pkg::ACT_SET) begin
			if (used_q < cap_eff) begin
				wr_fill = 1'b1;
				do_age  = 1'b1;
				age_all = 1'b1;
				mru_idx = used_q[IW-1:0];
			end else if (any_q) begin
				wr_evict = 1'b1;
				do_age   = 1'b1;
				mru_idx  = vidx_q;
				old_rank = vrank_q;
			end
		end
		do_wr  = (state_q == lkv_pkg::ST_FINISH) &&
			((found_q && act_q == lkv_pkg::ACT_SET) || wr_fill || wr_evict);
		wr_idx = mru_idx;
	end

	// Key and value memories: one read and at most one write per cycle.
	logic [IW-1:0] rd_addr;
	assign rd_addr = idx_q[IW-1:0];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			val_mem[wr_idx] <= val_q;
			if (!found_q) key_mem[wr_idx] <= key_q;
		end
		rkey_q <= key_mem[rd_addr];
		rval_q <= val_mem[rd_addr];
	end

	// Walk control and search results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			rd_vld_q <= 1'b0;
			found_q  <= 1'b0;
			any_q    <= 1'b0;
		end else begin
			rd_vld_q <= (state_q == lkv_pkg::ST_SCAN) && !scan_last;
			rd_idx_q <= rd_addr;
			if (accept) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				any_q   <= 1'b0;
			end else if (state_q == lkv_pkg::ST_SCAN) begin
				if (!scan_last) idx_q <= idx_q + CW'(1);
				if (rd_vld_q && valid_q[rd_idx_q]) begin
					if (!found_q && rkey_q == key_q) begin
						found_q <= 1'b1;
						fidx_q  <= rd_idx_q;
						fval_q  <= rval_q;
					end
					if (!any_q || rank_q[rd_idx_q] > vrank_q) begin
						any_q   <= 1'b1;
						vidx_q  <= rd_idx_q;
						vrank_q <= rank_q[rd_idx_q];
						vkey_q  <= rkey_q;
					end
				end
			end
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= req.action;
			key_q <= KEY_BITS'(req.lookup_key);
			val_q <= VALUE_BITS'(req.store_value);
		end
	end

	// Valid bits, ranks and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
			for (int i = 0; i < CAPACITY; i++) rank_q[i] <= '0;
		end else if (state_q == lkv_pkg::ST_FINISH && do_age) begin
			for (int i = 0; i < CAPACITY; i++) begin
				if (IW'(i) == mru_idx) begin
					rank_q[i] <= '0;
				end else if (valid_q[i] && (age_all || rank_q[i] < old_rank)) begin
					rank_q[i] <= rank_q[i] + IW'(1);
				end
			end
			if (wr_fill) begin
				valid_q[mru_idx] <= 1'b1;
				used_q <= used_q + CW'(1);
			end
		end
	end

	// Response beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == lkv_pkg::ST_FINISH);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lkv_pkg::ST_FINISH) begin
			rsp_q.hit <= found_q;
			rsp_q.read_value <= (found_q && act_q == lkv_pkg::ACT_GET) ?
				31'(fval_q) : 31'd0;
			rsp_q.evicted <= wr_evict;
			rsp_q.evicted_key <= wr_evict ? 32'(vkey_q) : 32'd0;
		end
	end
endmodule
